>>> sv/spqsf_pkg.sv
package spqsf_pkg;

    localparam int unsigned DEF_POOL_DEPTH     = 1024;
    localparam int unsigned DEF_NUM_PRIORITIES = 4;
    localparam int unsigned DEF_SKIP_SLOTS     = 4;
    localparam int unsigned DEF_NUM_QUEUES     = 2;

    typedef enum logic [1:0] {
        REQ_ENQ      = 2'd0,
        REQ_DEQ      = 2'd1,
        REQ_SKIP_ADD = 2'd2,
        REQ_SKIP_CLR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NONE     = 2'd2,
        ST_SKIPFULL = 2'd3
    } t_status;

    typedef struct packed {
        t_req        req_type;
        logic        queue_sel;
        logic [1:0]  prio;
        logic [63:0] item_key;
        logic        at_front;
        logic [31:0] handle_in;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] handle_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_ENQ_RD,
        S_ENQ_LINK,
        S_DQ_LIST,
        S_DQ_RD,
        S_DQ_CHK
    } t_state;

    typedef struct packed {
        logic latch;
        logic enq_full;
        logic enq_link;
        logic dq_init;
        logic dq_head;
        logic dq_dec;
        logic dq_take;
        logic dq_adv;
        logic dq_none;
        logic skip_add;
        logic skip_clr;
    } t_cmd;

    typedef struct packed {
        t_req req_type;
        logic qok;
        logic fc_zero;
        logic list_ne;
        logic p_zero;
        logic last;
        logic skipped;
    } t_sts;

endpackage

>>> sv/spqsf_ctrl.sv
module spqsf_ctrl
    import spqsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_IDLE;
                unique case (i_sts.req_type)
                    REQ_ENQ: begin
                        if (i_sts.qok && !i_sts.fc_zero) n_state = S_ENQ_RD;
                    end
                    REQ_DEQ: begin
                        if (i_sts.qok) n_state = S_DQ_LIST;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ENQ_RD:   n_state = S_ENQ_LINK;
            S_ENQ_LINK: n_state = S_IDLE;
            S_DQ_LIST: begin
                if (i_sts.list_ne) n_state = S_DQ_RD;
                else if (i_sts.p_zero) n_state = S_IDLE;
            end
            S_DQ_RD: n_state = S_DQ_CHK;
            S_DQ_CHK: begin
                if (!i_sts.skipped) n_state = S_IDLE;
                else if (i_sts.last) n_state = i_sts.p_zero ? S_IDLE : S_DQ_LIST;
                else n_state = S_DQ_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.latch = start;
            S_DEC: begin
                unique case (i_sts.req_type)
                    REQ_ENQ: o_cmd.enq_full = !i_sts.qok || i_sts.fc_zero;
                    REQ_DEQ: begin
                        o_cmd.dq_init = i_sts.qok;
                        o_cmd.dq_none = !i_sts.qok;
                    end
                    REQ_SKIP_ADD: o_cmd.skip_add = 1'b1;
                    default:      o_cmd.skip_clr = 1'b1;
                endcase
            end
            S_ENQ_LINK: o_cmd.enq_link = 1'b1;
            S_DQ_LIST: begin
                o_cmd.dq_head = i_sts.list_ne;
                o_cmd.dq_none = !i_sts.list_ne && i_sts.p_zero;
                o_cmd.dq_dec  = !i_sts.list_ne && !i_sts.p_zero;
            end
            S_DQ_CHK: begin
                o_cmd.dq_take = !i_sts.skipped;
                o_cmd.dq_adv  = i_sts.skipped && !i_sts.last;
                o_cmd.dq_none = i_sts.skipped && i_sts.last && i_sts.p_zero;
                o_cmd.dq_dec  = i_sts.skipped && i_sts.last && !i_sts.p_zero;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_dec_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> ($past(r_state) == S_IDLE))
        else $error("decode not entered from idle");
    a_one_final_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.enq_full, o_cmd.enq_link, o_cmd.dq_take, o_cmd.dq_none,
                    o_cmd.skip_add, o_cmd.skip_clr}) <= 1)
        else $error("more than one result command");
    a_link_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENQ_LINK) |-> ($past(r_state) == S_ENQ_RD))
        else $error("link without free stack read");
`endif

endmodule

>>> sv/spqsf_dp.sv
module spqsf_dp
    import spqsf_pkg::*;
#(
    parameter int unsigned POOL_DEPTH     = DEF_POOL_DEPTH,
    parameter int unsigned NUM_PRIORITIES = DEF_NUM_PRIORITIES,
    parameter int unsigned SKIP_SLOTS     = DEF_SKIP_SLOTS,
    parameter int unsigned NUM_QUEUES     = DEF_NUM_QUEUES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_req,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_done,
    output t_out_item o_res
);

    localparam int unsigned PW  = $clog2(POOL_DEPTH);
    localparam int unsigned CW  = $clog2(POOL_DEPTH + 1);
    localparam int unsigned QD  = NUM_QUEUES * POOL_DEPTH;
    localparam int unsigned AW  = $clog2(QD);
    localparam int unsigned PRW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int unsigned SCW = $clog2(SKIP_SLOTS + 1);
    localparam int unsigned SIW = (SKIP_SLOTS > 1) ? $clog2(SKIP_SLOTS) : 1;

    t_in_item     r_in;
    logic         r_qok;
    logic [PRW-1:0] r_p;
    logic [PW-1:0]  r_cur, r_prev;
    logic           r_have_prev;

    logic [PW-1:0] r_head [NUM_QUEUES][NUM_PRIORITIES];
    logic [PW-1:0] r_tail [NUM_QUEUES][NUM_PRIORITIES];
    logic [NUM_PRIORITIES-1:0] r_ne [NUM_QUEUES];
    logic [CW-1:0] r_fc [NUM_QUEUES];
    logic [CW-1:0] r_lw [NUM_QUEUES];
    logic [63:0]   r_skip_keys [NUM_QUEUES][SKIP_SLOTS];
    logic [SCW-1:0] r_skip_cnt [NUM_QUEUES];

    logic [PW-1:0] r_stack_mem [QD];
    logic [PW-1:0] r_next_mem  [QD];
    logic [95:0]   r_data_mem  [QD];
    logic [PW-1:0] r_stack_rd, r_next_rd;
    logic [95:0]   r_data_rd;

    logic          r_done;
    t_out_item     r_res;

    logic          w_q;
    logic [AW-1:0] w_base;
    logic [PW-1:0] w_pop_idx, w_n, w_head, w_tail;
    logic [AW-1:0] w_stack_raddr, w_stack_waddr, w_node_raddr;
    logic          w_skipped, w_last;
    logic [63:0]   w_key_rd;
    logic [31:0]   w_handle_rd;
    logic          w_next_we;
    logic [AW-1:0] w_next_waddr;
    logic [PW-1:0] w_next_wdata;

    assign w_q       = r_in.queue_sel;
    assign w_base    = w_q ? AW'(POOL_DEPTH) : '0;
    assign w_pop_idx = PW'(r_fc[w_q] - CW'(1));
    assign w_n       = (CW'(w_pop_idx) < r_lw[w_q]) ? w_pop_idx : r_stack_rd;
    assign w_head    = r_head[w_q][r_p];
    assign w_tail    = r_tail[w_q][r_p];
    assign w_stack_raddr = w_base + AW'(w_pop_idx);
    assign w_stack_waddr = w_base + AW'(PW'(r_fc[w_q]));
    assign w_node_raddr  = w_base + AW'(r_cur);
    assign w_key_rd    = r_data_rd[95:32];
    assign w_handle_rd = r_data_rd[31:0];
    assign w_last      = (r_cur == w_tail);

    always_comb begin
        w_skipped = 1'b0;
        for (int i = 0; i < SKIP_SLOTS; i++) begin
            if ((SCW'(i) < r_skip_cnt[w_q]) && (r_skip_keys[w_q][i] == w_key_rd)) begin
                w_skipped = 1'b1;
            end
        end
    end

    always_comb begin
        w_next_we    = 1'b0;
        w_next_waddr = w_base + AW'(w_n);
        w_next_wdata = w_head;
        if (i_cmd.enq_link && r_ne[w_q][r_p]) begin
            w_next_we = 1'b1;
            if (!r_in.at_front) begin
                w_next_waddr = w_base + AW'(w_tail);
                w_next_wdata = w_n;
            end
        end else if (i_cmd.dq_take && r_have_prev && !w_last) begin
            w_next_we    = 1'b1;
            w_next_waddr = w_base + AW'(r_prev);
            w_next_wdata = r_next_rd;
        end
    end

    assign o_sts.req_type = r_in.req_type;
    assign o_sts.qok      = r_qok;
    assign o_sts.fc_zero  = (r_fc[w_q] == '0);
    assign o_sts.list_ne  = r_ne[w_q][r_p];
    assign o_sts.p_zero   = (r_p == '0);
    assign o_sts.last     = w_last;
    assign o_sts.skipped  = w_skipped;

    always_ff @(posedge i_clk) begin
        r_stack_rd <= r_stack_mem[w_stack_raddr];
        if (i_cmd.dq_take && (r_fc[w_q] < CW'(POOL_DEPTH))) begin
            r_stack_mem[w_stack_waddr] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_rd <= r_next_mem[w_node_raddr];
        if (w_next_we) begin
            r_next_mem[w_next_waddr] <= w_next_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_rd <= r_data_mem[w_node_raddr];
        if (i_cmd.enq_link) begin
            r_data_mem[w_base + AW'(w_n)] <= {r_in.item_key, r_in.handle_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in  <= i_req;
            r_qok <= (32'(i_req.queue_sel) < NUM_QUEUES);
            r_p   <= (32'(i_req.prio) < NUM_PRIORITIES) ? PRW'(i_req.prio) : '0;
        end else if (i_cmd.dq_init) begin
            r_p <= PRW'(NUM_PRIORITIES - 1);
        end else if (i_cmd.dq_dec) begin
            r_p <= r_p - PRW'(1);
        end
        if (i_cmd.dq_head) begin
            r_cur       <= w_head;
            r_have_prev <= 1'b0;
        end else if (i_cmd.dq_adv) begin
            r_prev      <= r_cur;
            r_cur       <= r_next_rd;
            r_have_prev <= 1'b1;
        end
        if (i_cmd.enq_link) begin
            if (!r_ne[w_q][r_p]) begin
                r_head[w_q][r_p] <= w_n;
                r_tail[w_q][r_p] <= w_n;
            end else if (r_in.at_front) begin
                r_head[w_q][r_p] <= w_n;
            end else begin
                r_tail[w_q][r_p] <= w_n;
            end
        end
        if (i_cmd.dq_take && (r_have_prev || !w_last)) begin
            if (!r_have_prev) r_head[w_q][r_p] <= r_next_rd;
            else if (w_last) r_tail[w_q][r_p] <= r_prev;
        end
        if (i_cmd.skip_add && r_qok && (r_skip_cnt[w_q] < SCW'(SKIP_SLOTS))) begin
            r_skip_keys[w_q][SIW'(r_skip_cnt[w_q])] <= r_in.item_key;
        end
        r_res.handle_out <= i_cmd.dq_take ? w_handle_rd : '0;
        if (i_cmd.enq_full) r_res.status <= ST_FULL;
        if (i_cmd.enq_link) r_res.status <= ST_OK;
        if (i_cmd.dq_none)  r_res.status <= ST_NONE;
        if (i_cmd.skip_clr) r_res.status <= ST_OK;
        if (i_cmd.skip_add) begin
            r_res.status <= (r_qok && (r_skip_cnt[w_q] < SCW'(SKIP_SLOTS))) ? ST_OK
                                                                          : ST_SKIPFULL;
        end
        if (i_cmd.dq_take) begin
            r_res.status <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_ne[q]       <= '0;
                r_fc[q]       <= CW'(POOL_DEPTH);
                r_lw[q]       <= CW'(POOL_DEPTH);
                r_skip_cnt[q] <= '0;
            end
        end else begin
            r_done <= i_cmd.enq_full | i_cmd.enq_link | i_cmd.dq_none | i_cmd.dq_take |
                      i_cmd.skip_add | i_cmd.skip_clr;
            if (i_cmd.enq_link) begin
                r_ne[w_q][r_p] <= 1'b1;
                r_fc[w_q]      <= r_fc[w_q] - CW'(1);
                if (CW'(w_pop_idx) < r_lw[w_q]) r_lw[w_q] <= CW'(w_pop_idx);
            end
            if (i_cmd.dq_take) begin
                if (w_last && !r_have_prev) r_ne[w_q][r_p] <= 1'b0;
                if (r_fc[w_q] < CW'(POOL_DEPTH)) r_fc[w_q] <= r_fc[w_q] + CW'(1);
            end
            if (i_cmd.skip_add && r_qok && (r_skip_cnt[w_q] < SCW'(SKIP_SLOTS))) begin
                r_skip_cnt[w_q] <= r_skip_cnt[w_q] + SCW'(1);
            end
            if (i_cmd.skip_clr && r_qok) r_skip_cnt[w_q] <= '0;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc[0] <= CW'(POOL_DEPTH))
        else $error("free count above pool depth");
    a_lw_below_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lw[0] <= r_fc[0])
        else $error("free stack low mark above free count");
    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip_cnt[0] <= SCW'(SKIP_SLOTS))
        else $error("skip count above slot count");
`endif

endmodule

>>> sv/strict_priority_queue_with_skip_filter.sv
// Two-queue strict-priority manager with a per-queue skip list. An item is taken when
// start is high and busy low; exactly one result follows, on o_res for one cycle with
// o_done high, and it cannot be held off. Skip add/clear and a refused enqueue end in
// the decode state; a normal enqueue goes on to a free stack read and then the link. A
// dequeue visits priority levels from the highest down, node by node in list order; each
// step of the list walk waits on one registered read of the node memory. Results keep
// request order; all state is ready right after reset with no clearing pass.
module strict_priority_queue_with_skip_filter
    import spqsf_pkg::*;
#(
    parameter int unsigned POOL_DEPTH     = DEF_POOL_DEPTH,
    parameter int unsigned NUM_PRIORITIES = DEF_NUM_PRIORITIES,
    parameter int unsigned SKIP_SLOTS     = DEF_SKIP_SLOTS,
    parameter int unsigned NUM_QUEUES     = DEF_NUM_QUEUES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_req,
    output logic      o_done,
    output t_out_item o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    spqsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    spqsf_dp #(
        .POOL_DEPTH     (POOL_DEPTH),
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .SKIP_SLOTS     (SKIP_SLOTS),
        .NUM_QUEUES     (NUM_QUEUES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule
